FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk_i; one is disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define LLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every rising edge, reset included
`define LLI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/lli_pkg.sv
// ---------------------------------------------------------------------------
// lli_pkg
// Types shared by the two-line intersection pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lli_pkg;

  typedef struct packed {
    logic valid;
    logic vert;
  } lli_line_flags_t;

endpackage

FILE: rtl/core/line_line_intersection_2d_top.sv
// Throughput: one pair of lines per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline; input is taken whenever the output slot can move.
// Reset: rst_ni asynchronous, active low, clears all valid bits; no clearing pass.
// ---------------------------------------------------------------------------
// line_line_intersection_2d_top
// Crossing point of two lines in signed fixed point, deep pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module line_line_intersection_2d_top #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] dir1_x_i,
  input  logic [COORD_WIDTH-1:0] dir1_y_i,
  input  logic [COORD_WIDTH-1:0] pt1_x_i,
  input  logic [COORD_WIDTH-1:0] pt1_y_i,
  input  logic [COORD_WIDTH-1:0] dir2_x_i,
  input  logic [COORD_WIDTH-1:0] dir2_y_i,
  input  logic [COORD_WIDTH-1:0] pt2_x_i,
  input  logic [COORD_WIDTH-1:0] pt2_y_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_WIDTH-1:0] cross_x_o,
  output logic [COORD_WIDTH-1:0] cross_y_o,
  output logic                   parallel_o
);
  import lli_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned NW = W + 1 + F;
  localparam int unsigned PW = 4 + 5 * W;
  localparam int unsigned SW = 2 * W + 1;

  logic en;
  logic out_v_q;
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  lli_line_flags_t f1, f2;
  logic [W-1:0] s1, s2, o1, o2, a1x, a2x, a1y, a2y;

  lli_line #(.W(W), .F(F)) u_line1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .dx_i(dir1_x_i), .dy_i(dir1_y_i), .px_i(pt1_x_i), .py_i(pt1_y_i),
    .flags_o(f1), .slope_o(s1), .off_o(o1), .ax_o(a1x), .ay_o(a1y)
  );

  lli_line #(.W(W), .F(F)) u_line2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .dx_i(dir2_x_i), .dy_i(dir2_y_i), .px_i(pt2_x_i), .py_i(pt2_y_i),
    .flags_o(f2), .slope_o(s2), .off_o(o2), .ax_o(a2x), .ay_o(a2y)
  );

  logic               par, h1, h2, yconst;
  logic [W-1:0]       ay_sel, ys, yo;
  logic [W:0]         od, den;
  logic signed [NW-1:0] num;
  assign par    = (f1.vert && f2.vert) || (!f1.vert && !f2.vert && s1 == s2);
  assign h1     = !f1.vert && s1 == '0;
  assign h2     = !f2.vert && s2 == '0;
  assign yconst = h1 || h2;
  assign ay_sel = h1 ? a1y : a2y;
  assign ys     = f1.vert ? s2 : s1;
  assign yo     = f1.vert ? o2 : o1;
  assign od     = {o2[W-1], o2} - {o1[W-1], o1};
  assign den    = {s1[W-1], s1} - {s2[W-1], s2};
  assign num    = NW'(signed'(od)) <<< F;

  logic          dv;
  logic [W-1:0]  q;
  logic [PW-1:0] side;

  lli_div #(.NW(NW), .DW(W + 1), .OW(W), .PW(PW)) u_xdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f1.valid && f2.valid),
    .num_i   (num),
    .den_i   (den),
    .side_i  ({par, f1.vert, f2.vert, yconst, a1x, a2x, ay_sel, ys, yo}),
    .valid_o (dv),
    .quo_o   (q),
    .side_o  (side)
  );

  logic                  d_par, d_v1, d_v2, d_yc;
  logic [W-1:0]          d_a1x, d_a2x, d_ay, d_ys, d_yo, x;
  assign {d_par, d_v1, d_v2, d_yc, d_a1x, d_a2x, d_ay, d_ys, d_yo} = side;
  assign x = d_v1 ? d_a1x : (d_v2 ? d_a2x : q);

  logic                  vx_q;
  logic                  x_par_q, x_yc_q;
  logic [W-1:0]          x_q, x_ay_q, x_yo_q;
  logic signed [2*W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vx_q    <= dv;
      out_v_q <= vx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q     <= x;
      prod_q  <= signed'(d_ys) * signed'(x);
      x_par_q <= d_par;
      x_yc_q  <= d_yc;
      x_ay_q  <= d_ay;
      x_yo_q  <= d_yo;
    end
  end

  logic signed [2*W-1:0] sh;
  logic [SW-1:0]         sum;
  logic                  sum_ovf;
  logic [W-1:0]          y;
  assign sh      = prod_q >>> F;
  assign sum     = {sh[2*W-1], sh} + {{(W+1){x_yo_q[W-1]}}, x_yo_q};
  assign sum_ovf = ~(&sum[SW-1:W-1]) & (|sum[SW-1:W-1]);
  assign y       = x_yc_q ? x_ay_q :
                   (sum_ovf ? {sum[SW-1], {(W-1){~sum[SW-1]}}} : sum[W-1:0]);

  logic [W-1:0] cx_q, cy_q;
  logic         par_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q  <= x_par_q ? '0 : x_q;
      cy_q  <= x_par_q ? '0 : y;
      par_q <= x_par_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign cross_x_o   = cx_q;
  assign cross_y_o   = cy_q;
  assign parallel_o  = par_q;

  `LLI_ASSERT(a_par_zero, out_valid_o && parallel_o |-> cross_x_o == '0 && cross_y_o == '0, "parallel result not zero")
  `LLI_ASSERT(a_stall_hold, !in_ready_o |=> $stable(vx_q), "pipeline moved during stall")
  `LLI_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o, "valid during reset")

endmodule

FILE: rtl/core/lli_div.sv
// ---------------------------------------------------------------------------
// lli_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero, zero divisor gives zero, quotient saturated to OW bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lli_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32,
  parameter int unsigned OW = 32,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [OW-1:0] quo_o,
  output logic [PW-1:0] side_o
);

  localparam int unsigned XW = NW + 1;

  logic [NW:0]   v_q;
  logic [NW-1:0] num_q  [NW+1];
  logic [DW-1:0] rem_q  [NW+1];
  logic [DW-1:0] dm_q   [NW+1];
  logic          neg_q  [NW+1];
  logic          dz_q   [NW+1];
  logic [PW-1:0] side_q [NW+1];

  logic          out_v_q;
  logic [OW-1:0] quo_q;
  logic [PW-1:0] side_out_q;

  logic [NW-1:0] num_abs;
  logic [DW-1:0] den_abs;
  assign num_abs = num_i[NW-1] ? (NW'(0) - num_i) : num_i;
  assign den_abs = den_i[DW-1] ? (DW'(0) - den_i) : den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[NW-1:0], valid_i};
      out_v_q <= v_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]  <= num_abs;
      rem_q[0]  <= '0;
      dm_q[0]   <= den_abs;
      neg_q[0]  <= num_i[NW-1] ^ den_i[DW-1];
      dz_q[0]   <= (den_i == '0);
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;
    assign r2   = {rem_q[k], num_q[k][NW-1]};
    assign diff = r2 - {1'b0, dm_q[k]};
    assign ge   = (r2 >= {1'b0, dm_q[k]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
        num_q[k+1]  <= {num_q[k][NW-2:0], ge};
        dm_q[k+1]   <= dm_q[k];
        neg_q[k+1]  <= neg_q[k];
        dz_q[k+1]   <= dz_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  logic [XW-1:0] sq;
  logic          ovf;
  logic [OW-1:0] sat;
  assign sq  = dz_q[NW] ? '0 :
               (neg_q[NW] ? (XW'(0) - {1'b0, num_q[NW]}) : {1'b0, num_q[NW]});
  assign ovf = ~(&sq[XW-1:OW-1]) & (|sq[XW-1:OW-1]);
  assign sat = ovf ? {sq[XW-1], {(OW-1){~sq[XW-1]}}} : sq[OW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q      <= sat;
      side_out_q <= side_q[NW];
    end
  end

  assign valid_o = out_v_q;
  assign quo_o   = quo_q;
  assign side_o  = side_out_q;

endmodule

FILE: rtl/core/lli_line.sv
// ---------------------------------------------------------------------------
// lli_line
// Per-line front end: end point, slope by division, offset by multiply.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lli_line #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [W-1:0]             dx_i,
  input  logic [W-1:0]             dy_i,
  input  logic [W-1:0]             px_i,
  input  logic [W-1:0]             py_i,
  output lli_pkg::lli_line_flags_t flags_o,
  output logic [W-1:0]             slope_o,
  output logic [W-1:0]             off_o,
  output logic [W-1:0]             ax_o,
  output logic [W-1:0]             ay_o
);
  import lli_pkg::*;

  localparam int unsigned NW = W + F;
  localparam int unsigned PW = 2 * W + 1;
  localparam int unsigned SW = 2 * W + 1;

  logic [W:0]   sx, sy;
  logic [W-1:0] ax, ay;
  logic         sx_ovf, sy_ovf;
  assign sx     = {px_i[W-1], px_i} + {dx_i[W-1], dx_i};
  assign sy     = {py_i[W-1], py_i} + {dy_i[W-1], dy_i};
  assign sx_ovf = sx[W] ^ sx[W-1];
  assign sy_ovf = sy[W] ^ sy[W-1];
  assign ax     = sx_ovf ? {sx[W], {(W-1){~sx[W]}}} : sx[W-1:0];
  assign ay     = sy_ovf ? {sy[W], {(W-1){~sy[W]}}} : sy[W-1:0];

  logic signed [NW-1:0] num;
  assign num = NW'(signed'(dy_i)) <<< F;

  logic          dv;
  logic [W-1:0]  slope;
  logic [PW-1:0] side;

  lli_div #(.NW(NW), .DW(W), .OW(W), .PW(PW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .num_i   (num),
    .den_i   (dx_i),
    .side_i  ({(dx_i == '0), ax, ay}),
    .valid_o (dv),
    .quo_o   (slope),
    .side_o  (side)
  );

  logic                m_v_q, o_v_q;
  logic signed [2*W-1:0] prod_q;
  logic [W-1:0]        m_slope_q, m_ax_q, m_ay_q;
  logic                m_vert_q;
  logic [W-1:0]        o_slope_q, o_off_q, o_ax_q, o_ay_q;
  logic                o_vert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en_i) begin
      m_v_q <= dv;
      o_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= signed'(slope) * signed'(side[2*W-1:W]);
      m_slope_q <= slope;
      m_vert_q  <= side[2*W];
      m_ax_q    <= side[2*W-1:W];
      m_ay_q    <= side[W-1:0];
    end
  end

  logic signed [2*W-1:0] sh;
  logic [SW-1:0]         dif;
  logic                  dif_ovf;
  logic [W-1:0]          off;
  assign sh      = prod_q >>> F;
  assign dif     = {{(W+1){m_ay_q[W-1]}}, m_ay_q} - {sh[2*W-1], sh};
  assign dif_ovf = ~(&dif[SW-1:W-1]) & (|dif[SW-1:W-1]);
  assign off     = m_vert_q ? '0 :
                   (dif_ovf ? {dif[SW-1], {(W-1){~dif[SW-1]}}} : dif[W-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_slope_q <= m_slope_q;
      o_off_q   <= off;
      o_ax_q    <= m_ax_q;
      o_ay_q    <= m_ay_q;
      o_vert_q  <= m_vert_q;
    end
  end

  assign flags_o.valid = o_v_q;
  assign flags_o.vert  = o_vert_q;
  assign slope_o       = o_slope_q;
  assign off_o         = o_off_q;
  assign ax_o          = o_ax_q;
  assign ay_o          = o_ay_q;

endmodule
